// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = IDX_W + 1;
    localparam int ARR_W    = IDX_W;
    localparam int SYM_W    = 8;
    localparam int PRI_W    = 16;

    typedef struct packed {
        logic [SYM_W-1:0]        symbol;
        logic signed [PRI_W-1:0] prio;
        logic [ARR_W-1:0]        arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DRAIN  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ENTRY    = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_D_RD_ROOT,
        S_D_ROOT,
        S_D_OUT,
        S_D_LAST,
        S_D_RDL,
        S_D_RDR,
        S_D_SEL,
        S_D_DEC
    } state_t;

    // ordering key: priority, then arrival number
    function automatic logic precedes(input entry_t x, input entry_t y);
        if (x.prio != y.prio) begin
            return x.prio < y.prio;
        end
        return x.arrival < y.arrival;
    endfunction

endpackage

// ===== design/mhpq_ram.sv =====
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== design/min_heap_priority_queue_top.sv =====
// binary min-heap priority queue of (symbol, priority) entries held in one
// synchronous ram of CAPACITY entries. an insert request is stored and sifted
// up with a moving hole, each level a parent read and then a compare and
// write; no result comes back unless the queue is full, then one overflow
// result echoes the entry. a drain request hands out all entries in
// ascending priority (ties in insertion order) and empties the queue; each
// entry is fetched from the root and presented, then the last entry is
// sifted down level by level, all bound by the single read port of the ram.
// a drain of an empty queue gives one empty result.
// a new request is taken only when the sequencer is idle and no result waits.
module min_heap_priority_queue_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [7:0]                    s_symbol,
    input  logic signed [15:0]            s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_symbol_res,
    output logic signed [15:0]            m_priority_res,
    output logic [1:0]                    m_status,
    output logic                          m_last
);
    import mhpq_pkg::*;

    // sequencer state and counters
    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ARR_W-1:0]     arr_reg, arr_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     cidx_reg, cidx_next;
    entry_t               cur_reg, cur_next;
    entry_t               child_reg, child_next;

    // result register
    logic                 mv_reg, mv_next;
    logic [SYM_W-1:0]     msym_reg, msym_next;
    logic [PRI_W-1:0]     mpri_reg, mpri_next;
    status_t              mst_reg, mst_next;
    logic                 mlast_reg, mlast_next;

    // ram port
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    entry_t               wr_data, rd_data;
    logic [ENTRY_W-1:0]   rd_raw;

    logic                 s_fire, m_fire;
    logic [IDX_W-1:0]     par_idx;
    logic [IDX_W:0]       lc_w;
    logic [IDX_W+1:0]     rc_w;
    logic                 lc_in, rc_in;

    mhpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );
    assign rd_data = entry_t'(rd_raw);

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = mv_reg && m_ready;

    // heap index arithmetic
    assign par_idx = IDX_W'((pos_reg - 1'b1) >> 1);
    assign lc_w    = {pos_reg, 1'b1};
    assign rc_w    = {1'b0, lc_w} + 1'b1;
    assign lc_in   = {1'b0, lc_w} < {1'b0, count_reg};
    assign rc_in   = rc_w < {1'b0, count_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_op == OP_INSERT) begin
                        if (count_reg < COUNT_W'(CAPACITY)) begin
                            state_next = S_INS_RD;
                        end
                    end else if (count_reg != '0) begin
                        state_next = S_D_RD_ROOT;
                    end
                end
            end
            S_INS_RD:    state_next = (pos_reg == '0) ? S_IDLE : S_INS_CMP;
            S_INS_CMP:   state_next = precedes(cur_reg, rd_data) ? S_INS_RD : S_IDLE;
            S_D_RD_ROOT: state_next = S_D_ROOT;
            S_D_ROOT:    state_next = S_D_OUT;
            S_D_OUT: begin
                if (m_fire) begin
                    state_next = (count_reg == COUNT_W'(1)) ? S_IDLE : S_D_LAST;
                end
            end
            S_D_LAST:    state_next = S_D_RDL;
            S_D_RDL:     state_next = lc_in ? S_D_RDR : S_D_RD_ROOT;
            S_D_RDR:     state_next = rc_in ? S_D_SEL : S_D_DEC;
            S_D_SEL:     state_next = S_D_DEC;
            S_D_DEC:     state_next = precedes(child_reg, cur_reg) ? S_D_RDL : S_D_RD_ROOT;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        count_next = count_reg;
        arr_next   = arr_reg;
        pos_next   = pos_reg;
        cidx_next  = cidx_reg;
        cur_next   = cur_reg;
        child_next = child_reg;
        mv_next    = mv_reg && !m_ready;
        msym_next  = msym_reg;
        mpri_next  = mpri_reg;
        mst_next   = mst_reg;
        mlast_next = mlast_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = cur_reg;
        rd_addr    = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_op == OP_INSERT) begin
                        if (count_reg < COUNT_W'(CAPACITY)) begin
                            cur_next   = '{symbol: s_symbol, prio: s_priority_req,
                                           arrival: arr_reg};
                            pos_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            arr_next   = arr_reg + 1'b1;
                        end else begin
                            // full: drop and echo
                            mv_next    = 1'b1;
                            msym_next  = s_symbol;
                            mpri_next  = s_priority_req;
                            mst_next   = ST_OVERFLOW;
                            mlast_next = 1'b1;
                        end
                    end else begin
                        arr_next = '0;
                        if (count_reg == '0) begin
                            mv_next    = 1'b1;
                            msym_next  = '0;
                            mpri_next  = '0;
                            mst_next   = ST_EMPTY;
                            mlast_next = 1'b1;
                        end
                    end
                end
            end
            S_INS_RD: begin
                rd_addr = par_idx;
                if (pos_reg == '0) begin
                    wr_en = 1'b1;
                end
            end
            S_INS_CMP: begin
                wr_en = 1'b1;
                if (precedes(cur_reg, rd_data)) begin
                    wr_data  = rd_data;
                    pos_next = par_idx;
                end
            end
            S_D_RD_ROOT: rd_addr = '0;
            S_D_ROOT: begin
                mv_next    = 1'b1;
                msym_next  = rd_data.symbol;
                mpri_next  = rd_data.prio;
                mst_next   = ST_ENTRY;
                mlast_next = (count_reg == COUNT_W'(1));
            end
            S_D_OUT: begin
                if (m_fire) begin
                    count_next = count_reg - 1'b1;
                    rd_addr    = count_next[IDX_W-1:0];
                end
            end
            S_D_LAST: begin
                cur_next = rd_data;
                pos_next = '0;
            end
            S_D_RDL: begin
                rd_addr = lc_w[IDX_W-1:0];
                if (!lc_in) begin
                    wr_en = 1'b1;
                end
            end
            S_D_RDR: begin
                child_next = rd_data;
                cidx_next  = lc_w[IDX_W-1:0];
                rd_addr    = rc_w[IDX_W-1:0];
            end
            S_D_SEL: begin
                if (precedes(rd_data, child_reg)) begin
                    child_next = rd_data;
                    cidx_next  = rc_w[IDX_W-1:0];
                end
            end
            S_D_DEC: begin
                wr_en = 1'b1;
                if (precedes(child_reg, cur_reg)) begin
                    wr_data  = child_reg;
                    pos_next = cidx_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            arr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            arr_reg   <= arr_next;
            mv_reg    <= mv_next;
        end
        pos_reg   <= pos_next;
        cidx_reg  <= cidx_next;
        cur_reg   <= cur_next;
        child_reg <= child_next;
        msym_reg  <= msym_next;
        mpri_reg  <= mpri_next;
        mst_reg   <= mst_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid        = mv_reg;
    assign m_symbol_res   = msym_reg;
    assign m_priority_res = mpri_reg;
    assign m_status       = mst_reg;
    assign m_last         = mlast_reg;

    // count never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // no ram write while waiting for a request or a result handoff
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_D_OUT) |-> !wr_en)
        else $error("ram write outside a sift");

    // the last result of a drain leaves the queue empty
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_D_OUT && m_fire && m_last) |=> (count_reg == '0))
        else $error("drain ended with entries left");

    // arrival numbers restart after each drain request
    a_arr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == OP_DRAIN) |=> (arr_reg == '0))
        else $error("arrival counter not cleared by drain");
endmodule
